// ===== src/psa_pkg.sv =====
// Shared definitions for the polygon separating axis core.
// Holds default sizes, field widths, item opcodes and the pipeline tag type.
// No dependencies.
package psa_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int NORMAL_W         = 16;
   localparam int SEP_W            = 35;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_EVAL   = 2'd2;

   // Travels with each vertex pair through the projection pipeline.
   typedef struct packed {
      logic valid;
      logic phase;   // 0: edges of A against B's vertices, 1: edges of B against A's
      logic first;   // first vertex of the inner sweep
      logic last;    // last vertex of the inner sweep
   } psa_tag_type;

endpackage

// ===== src/psa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/psa_proj_pipe.sv =====
// Projection pipeline: difference, products, sum, running minimum, running best.
// Depends on psa_pkg (tag type, normal width).
module psa_proj_pipe #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  clear,
   input  psa_pkg::psa_tag_type                                  tag,
   input  logic [2*COORD_WIDTH+2*psa_pkg::NORMAL_W-1:0]          rd_a,
   input  logic [2*COORD_WIDTH+2*psa_pkg::NORMAL_W-1:0]          rd_b,
   output logic signed [COORD_WIDTH+psa_pkg::NORMAL_W+1:0]       best,
   output logic signed [psa_pkg::NORMAL_W-1:0]                   axis_x,
   output logic signed [psa_pkg::NORMAL_W-1:0]                   axis_y,
   output logic                                                  active
);
   import psa_pkg::*;

   localparam int ENTRY_W = 2*COORD_WIDTH + 2*NORMAL_W;
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = DIFF_W + NORMAL_W;
   localparam int SUM_W   = PROD_W + 1;

   logic [ENTRY_W-1:0]        base_w, other_w;
   logic signed [COORD_WIDTH-1:0] bx, by, ox, oy;
   logic signed [NORMAL_W-1:0]    bnx, bny;

   psa_tag_type               s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic signed [DIFF_W-1:0]  s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic signed [NORMAL_W-1:0] s1_nx_ff, s1_ny_ff, s2_nx_ff, s2_ny_ff;
   logic signed [NORMAL_W-1:0] s3_nx_ff, s3_ny_ff, s4_nx_ff, s4_ny_ff;
   logic signed [PROD_W-1:0]  s2_px_ff, s2_py_ff, s2_px_in, s2_py_in;
   logic signed [SUM_W-1:0]   s3_sum_ff, s3_sum_in;
   logic signed [SUM_W-1:0]   min_ff, best_ff;
   logic signed [NORMAL_W-1:0] ax_ff, ay_ff;
   logic                      have_ff;
   logic                      take_best;

   // The base vertex comes from A in the first sweep and from B in the second.
   always_comb begin
      base_w  = tag.phase ? rd_b : rd_a;
      other_w = tag.phase ? rd_a : rd_b;
      bx  = base_w[ENTRY_W-1 -: COORD_WIDTH];
      by  = base_w[ENTRY_W-1-COORD_WIDTH -: COORD_WIDTH];
      bnx = base_w[2*NORMAL_W-1 -: NORMAL_W];
      bny = base_w[NORMAL_W-1:0];
      ox  = other_w[ENTRY_W-1 -: COORD_WIDTH];
      oy  = other_w[ENTRY_W-1-COORD_WIDTH -: COORD_WIDTH];
      s1_dx_in  = DIFF_W'(ox) - DIFF_W'(bx);
      s1_dy_in  = DIFF_W'(oy) - DIFF_W'(by);
      s2_px_in  = PROD_W'(s1_dx_ff) * PROD_W'(s1_nx_ff);
      s2_py_in  = PROD_W'(s1_dy_ff) * PROD_W'(s1_ny_ff);
      s3_sum_in = SUM_W'(s2_px_ff) + SUM_W'(s2_py_ff);
      take_best = s4_tag_ff.valid && s4_tag_ff.last && (!have_ff || (min_ff > best_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
         have_ff   <= 1'b0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
         if (clear) begin
            have_ff <= 1'b0;
         end else if (take_best) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff  <= s1_dx_in;
      s1_dy_ff  <= s1_dy_in;
      s1_nx_ff  <= bnx;
      s1_ny_ff  <= bny;
      s2_px_ff  <= s2_px_in;
      s2_py_ff  <= s2_py_in;
      s2_nx_ff  <= s1_nx_ff;
      s2_ny_ff  <= s1_ny_ff;
      s3_sum_ff <= s3_sum_in;
      s3_nx_ff  <= s2_nx_ff;
      s3_ny_ff  <= s2_ny_ff;
      s4_nx_ff  <= s3_nx_ff;
      s4_ny_ff  <= s3_ny_ff;
      if (s3_tag_ff.valid && (s3_tag_ff.first || (s3_sum_ff < min_ff))) begin
         min_ff <= s3_sum_ff;
      end
      // B's normals point away from A, so the axis is turned round for them.
      if (take_best) begin
         best_ff <= min_ff;
         ax_ff   <= s4_tag_ff.phase ? -s4_nx_ff : s4_nx_ff;
         ay_ff   <= s4_tag_ff.phase ? -s4_ny_ff : s4_ny_ff;
      end
   end

   assign best   = best_ff;
   assign axis_x = ax_ff;
   assign axis_y = ay_ff;
   assign active = tag.valid | s1_tag_ff.valid | s2_tag_ff.valid | s3_tag_ff.valid |
                   s4_tag_ff.valid;

endmodule

// ===== src/polygon_separating_axis_core.sv =====
// Top level of the 2-D separating axis core for two convex polygons.
// Depends on psa_pkg, psa_ram (vertex stores) and psa_proj_pipe (projection unit).
//
//  Channel   Handshake               Ports
//  --------  ----------------------  --------------------------------------------------
//  request   start & !busy           req_opcode, req_point_x/y, req_normal_x/y
//  response  rsp_strobe, one cycle   rsp_separation, rsp_axis_x/y, rsp_valid_res,
//                                    rsp_overflowed
//
// A vertex load leaves busy low, so loads may arrive back to back.
// An evaluate item with both polygons loaded feeds one vertex pair per cycle into the
// shared projection pipeline, set by its single pair of multipliers and the one read port
// of each vertex store, and then waits for the pipeline to drain.
// An evaluate item with an empty polygon answers in the cycle after it is accepted.
// Reset is synchronous; it empties both polygons and clears the overflow flag.
// The response cannot be stalled: the result is shown for exactly one cycle.
module polygon_separating_axis_core #(
   parameter int MAX_VERTICES = psa_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = psa_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  logic signed [COORD_WIDTH-1:0]         req_point_x,
   input  logic signed [COORD_WIDTH-1:0]         req_point_y,
   input  logic signed [psa_pkg::NORMAL_W-1:0]   req_normal_x,
   input  logic signed [psa_pkg::NORMAL_W-1:0]   req_normal_y,
   output logic                                  rsp_strobe,
   output logic signed [psa_pkg::SEP_W-1:0]      rsp_separation,
   output logic signed [psa_pkg::NORMAL_W-1:0]   rsp_axis_x,
   output logic signed [psa_pkg::NORMAL_W-1:0]   rsp_axis_y,
   output logic                                  rsp_valid_res,
   output logic                                  rsp_overflowed
);
   import psa_pkg::*;

   localparam int ENTRY_W = 2*COORD_WIDTH + 2*NORMAL_W;
   localparam int AW      = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W   = COORD_WIDTH + NORMAL_W + 2;
   localparam int EXT_W   = (SUM_W > SEP_W) ? SUM_W : SEP_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam logic signed [SEP_W-1:0] SEP_MAX_C = {1'b0, {(SEP_W-1){1'b1}}};
   localparam logic signed [SEP_W-1:0] SEP_MIN_C = {1'b1, {(SEP_W-1){1'b0}}};

   logic [1:0]       state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [AW-1:0]    i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic             dropped_ff, dropped_in;
   psa_tag_type      tag_ff, tag_in;

   logic                       rsp_strobe_ff;
   logic signed [SEP_W-1:0]    rsp_sep_ff;
   logic signed [NORMAL_W-1:0] rsp_ax_ff, rsp_ay_ff;
   logic                       rsp_valid_ff, rsp_ovf_ff;

   logic             accept, load_a, load_b, eval_go, eval_empty, finish;
   logic             full_a, full_b, j_last, i_last;
   logic [CNT_W-1:0] base_cnt, other_cnt;
   logic [AW-1:0]    addr_a, addr_b;
   logic [ENTRY_W-1:0] wr_word, rd_a, rd_b;

   logic signed [SUM_W-1:0]    pipe_best;
   logic signed [NORMAL_W-1:0] pipe_ax, pipe_ay;
   logic                       pipe_active;
   logic signed [EXT_W-1:0]    best_ext;
   logic signed [SEP_W-1:0]    sep_sat;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full_a = (cnt_a_ff == CNT_W'(MAX_VERTICES));
   assign full_b = (cnt_b_ff == CNT_W'(MAX_VERTICES));
   assign load_a = accept && (req_opcode == OP_LOAD_A) && !full_a;
   assign load_b = accept && (req_opcode == OP_LOAD_B) && !full_b;
   assign eval_go    = accept && (req_opcode == OP_EVAL) &&
                       (cnt_a_ff != '0) && (cnt_b_ff != '0);
   assign eval_empty = accept && (req_opcode == OP_EVAL) &&
                       ((cnt_a_ff == '0) || (cnt_b_ff == '0));
   // The answer is final once the last candidate has left the pipeline.
   assign finish  = (state_ff == ST_DRAIN) && !pipe_active;
   assign wr_word = {req_point_x, req_point_y, req_normal_x, req_normal_y};

   // In the first sweep A supplies the edge and B the vertices; in the second the roles swap.
   always_comb begin
      base_cnt  = phase_ff ? cnt_b_ff : cnt_a_ff;
      other_cnt = phase_ff ? cnt_a_ff : cnt_b_ff;
      j_last    = ((CNT_W'(j_ff) + CNT_W'(1)) == other_cnt);
      i_last    = ((CNT_W'(i_ff) + CNT_W'(1)) == base_cnt);
      addr_a    = phase_ff ? j_ff : i_ff;
      addr_b    = phase_ff ? i_ff : j_ff;
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      dropped_in = dropped_ff;
      tag_in     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (load_a) begin
               cnt_a_in = cnt_a_ff + CNT_W'(1);
            end
            if (load_b) begin
               cnt_b_in = cnt_b_ff + CNT_W'(1);
            end
            if (accept && (((req_opcode == OP_LOAD_A) && full_a) ||
                           ((req_opcode == OP_LOAD_B) && full_b))) begin
               dropped_in = 1'b1;
            end
            if (eval_go) begin
               state_in = ST_RUN;
               phase_in = 1'b0;
               i_in     = '0;
               j_in     = '0;
            end
            if (eval_empty) begin
               cnt_a_in   = '0;
               cnt_b_in   = '0;
               dropped_in = 1'b0;
            end
         end
         ST_RUN: begin
            tag_in.valid = 1'b1;
            tag_in.phase = phase_ff;
            tag_in.first = (j_ff == '0);
            tag_in.last  = j_last;
            if (!j_last) begin
               j_in = j_ff + AW'(1);
            end else begin
               j_in = '0;
               if (!i_last) begin
                  i_in = i_ff + AW'(1);
               end else begin
                  i_in = '0;
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in   = ST_IDLE;
               cnt_a_in   = '0;
               cnt_b_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Saturate the widened best value to the separation field.
   always_comb begin
      best_ext = EXT_W'(pipe_best);
      if (best_ext > EXT_W'(SEP_MAX_C)) begin
         sep_sat = SEP_MAX_C;
      end else if (best_ext < EXT_W'(SEP_MIN_C)) begin
         sep_sat = SEP_MIN_C;
      end else begin
         sep_sat = best_ext[SEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         dropped_ff    <= 1'b0;
         tag_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         dropped_ff    <= dropped_in;
         tag_ff        <= tag_in;
         rsp_strobe_ff <= finish || eval_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_sep_ff   <= sep_sat;
         rsp_ax_ff    <= pipe_ax;
         rsp_ay_ff    <= pipe_ay;
         rsp_valid_ff <= 1'b1;
         rsp_ovf_ff   <= dropped_ff;
      end else if (eval_empty) begin
         rsp_sep_ff   <= '0;
         rsp_ax_ff    <= '0;
         rsp_ay_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   psa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_VERTICES)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (cnt_a_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   psa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_VERTICES)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (cnt_b_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   // The tag is registered so that it lines up with the registered store read.
   psa_proj_pipe #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_proj (
      .clock  (clock),
      .reset  (reset),
      .clear  (eval_go),
      .tag    (tag_ff),
      .rd_a   (rd_a),
      .rd_b   (rd_b),
      .best   (pipe_best),
      .axis_x (pipe_ax),
      .axis_y (pipe_ay),
      .active (pipe_active)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_separation = rsp_sep_ff;
   assign rsp_axis_x     = rsp_ax_ff;
   assign rsp_axis_y     = rsp_ay_ff;
   assign rsp_valid_res  = rsp_valid_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

// ===== src/psa_checker.sv =====
// Port-level checks on the separating axis core, attached by a bind statement.
// Depends on psa_pkg (opcodes, field widths).
module psa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [1:0]                          req_opcode,
   input logic                                rsp_strobe,
   input logic signed [psa_pkg::SEP_W-1:0]    rsp_separation,
   input logic signed [psa_pkg::NORMAL_W-1:0] rsp_axis_x,
   input logic signed [psa_pkg::NORMAL_W-1:0] rsp_axis_y,
   input logic                                rsp_valid_res
);
   import psa_pkg::*;

   // A vertex load or an unused opcode never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != OP_EVAL)) |=> !rsp_strobe)
      else $error("result after a non-evaluate item");

   // An evaluate item either answers at once or starts a busy period.
   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_EVAL)) |=> (rsp_strobe || busy))
      else $error("evaluate item neither answered nor started");

   // A busy period always ends with its result.
   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // An empty polygon gives a cleared separation and axis.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |->
         ((rsp_separation == '0) && (rsp_axis_x == '0) && (rsp_axis_y == '0)))
      else $error("invalid result carries non-zero fields");

endmodule

bind polygon_separating_axis_core psa_checker u_psa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_opcode     (req_opcode),
   .rsp_strobe     (rsp_strobe),
   .rsp_separation (rsp_separation),
   .rsp_axis_x     (rsp_axis_x),
   .rsp_axis_y     (rsp_axis_y),
   .rsp_valid_res  (rsp_valid_res)
);
